// File: src/mbd_pkg.sv
`timescale 1ns / 1ps

package mbd_pkg;

   localparam int NumButtons = 4;
   localparam int TimeBits   = 32;
   localparam int DebBits    = 16;
   localparam int EventBits  = 3;
   localparam int KindBits   = 2;
   localparam int CsrIdxBits = 1;

   localparam logic [KindBits-1:0] KindSample  = 2'd0;
   localparam logic [KindBits-1:0] KindConsume = 2'd1;
   localparam logic [KindBits-1:0] KindCapture = 2'd2;

   localparam logic [CsrIdxBits-1:0] CsrDebounceMs = 1'd0;
   localparam logic [CsrIdxBits-1:0] CsrActiveLow  = 1'd1;

   localparam logic [EventBits-1:0] EventNone = 3'd0;

   localparam logic [DebBits-1:0] DebounceReset  = 16'd30;
   localparam logic               ActiveLowReset = 1'b1;

   // per-item command broadcast to every lane
   typedef struct packed {
      logic                sample;
      logic                capture;
      logic                consume;
      logic [TimeBits-1:0] now;
      logic [DebBits-1:0]  debounce;
   } mbd_lane_cmd_type;

   typedef struct packed {
      logic [EventBits-1:0]  press_event;
      logic [NumButtons-1:0] stable_pressed;
   } mbd_rsp_data_type;

endpackage

// File: src/mbd_if.sv
`timescale 1ns / 1ps

interface mbd_req_if;
   import mbd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [KindBits-1:0]   kind;
   logic [TimeBits-1:0]   now_ms;
   logic [NumButtons-1:0] pin_levels;

   modport source (output valid, kind, now_ms, pin_levels, input ready);
   modport sink   (input valid, kind, now_ms, pin_levels, output ready);
endinterface

interface mbd_rsp_if;
   import mbd_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [EventBits-1:0]  press_event;
   logic [NumButtons-1:0] stable_pressed;

   modport source (output valid, press_event, stable_pressed, input ready);
   modport sink   (input valid, press_event, stable_pressed, output ready);
endinterface

// File: src/mbd_lane.sv
`timescale 1ns / 1ps

module mbd_lane import mbd_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  mbd_lane_cmd_type cmd,
   input  logic             raw_bit,
   input  logic             grant,
   output logic             stable_next,
   output logic             pending
);

   logic                last_ff, last_in;
   logic                stable_ff, stable_in;
   logic                pending_ff, pending_in;
   logic [TimeBits-1:0] change_time_ff, change_time_in;
   logic [TimeBits-1:0] start_time;
   logic [TimeBits-1:0] elapsed;
   logic                changed;
   logic                held;

   always_comb begin
      changed    = raw_bit != last_ff;
      start_time = changed ? cmd.now : change_time_ff;
      elapsed    = cmd.now - start_time;
      held       = elapsed >= TimeBits'(cmd.debounce);

      last_in        = last_ff;
      stable_in      = stable_ff;
      pending_in     = pending_ff;
      change_time_in = change_time_ff;

      if (cmd.sample) begin
         last_in        = raw_bit;
         change_time_in = start_time;
         if (held && (raw_bit != stable_ff)) begin
            stable_in = raw_bit;
            if (raw_bit) begin
               pending_in = 1'b1;
            end
         end
      end
      if (cmd.capture) begin
         last_in        = raw_bit;
         stable_in      = raw_bit;
         change_time_in = cmd.now;
      end
      if (cmd.consume && grant) begin
         pending_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_ff        <= 1'b0;
         stable_ff      <= 1'b0;
         pending_ff     <= 1'b0;
         change_time_ff <= '0;
      end else begin
         last_ff        <= last_in;
         stable_ff      <= stable_in;
         pending_ff     <= pending_in;
         change_time_ff <= change_time_in;
      end
   end

   assign stable_next = stable_in;
   assign pending     = pending_ff;

endmodule

// File: src/mbd_merge.sv
`timescale 1ns / 1ps

module mbd_merge import mbd_pkg::*; (
   input  logic [NumButtons-1:0] pending,
   input  logic [NumButtons-1:0] stable_next,
   input  logic                  consume,
   output logic [NumButtons-1:0] grant,
   output mbd_rsp_data_type      result
);

   logic                 found;
   logic [EventBits-1:0] code;

   // lowest numbered pending button wins
   always_comb begin
      grant = '0;
      code  = EventNone;
      found = 1'b0;
      for (int i = 0; i < NumButtons; i++) begin
         if (pending[i] && !found) begin
            found    = 1'b1;
            grant[i] = 1'b1;
            code     = EventBits'(i + 1);
         end
      end
      result.press_event    = consume ? code : EventNone;
      result.stable_pressed = stable_next;
   end

endmodule

// File: src/multi_button_debouncer_with_press_events_unit.sv
`timescale 1ns / 1ps

// A result is registered in the output register, or in the skid entry when
// that is full and not being taken. Throughput: one item per cycle while the
// skid entry is empty; each lane does one 32-bit subtract and compare per
// item, and a two-entry output buffer takes one more item when rsp stalls.
// Reset (synchronous): clears all button state, empties the output buffer,
// debounce_ms returns to 30 and active_low to 1.
module multi_button_debouncer_with_press_events_unit import mbd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   mbd_req_if.sink               req,
   mbd_rsp_if.source             rsp,
   input  logic                  csr_we,
   input  logic [CsrIdxBits-1:0] csr_index,
   input  logic [DebBits-1:0]    csr_wdata
);

   logic [DebBits-1:0] debounce_ms_ff;
   logic               active_low_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         debounce_ms_ff <= DebounceReset;
         active_low_ff  <= ActiveLowReset;
      end else if (csr_we) begin
         unique case (csr_index)
            CsrDebounceMs: debounce_ms_ff <= csr_wdata;
            CsrActiveLow:  active_low_ff  <= csr_wdata[0];
            default:       ;
         endcase
      end
   end

   logic                  accept;
   logic [NumButtons-1:0] raw_pressed;
   mbd_lane_cmd_type      cmd;
   logic [NumButtons-1:0] stable_next;
   logic [NumButtons-1:0] pending;
   logic [NumButtons-1:0] grant;
   mbd_rsp_data_type      result;

   assign accept      = req.valid && req.ready;
   assign raw_pressed = active_low_ff ? ~req.pin_levels : req.pin_levels;

   always_comb begin
      cmd.sample   = accept && (req.kind == KindSample);
      cmd.capture  = accept && (req.kind == KindCapture);
      cmd.consume  = accept && (req.kind == KindConsume);
      cmd.now      = req.now_ms;
      cmd.debounce = debounce_ms_ff;
   end

   for (genvar g = 0; g < NumButtons; g++) begin : g_lane
      mbd_lane u_lane (
         .clock       (clock),
         .reset       (reset),
         .cmd         (cmd),
         .raw_bit     (raw_pressed[g]),
         .grant       (grant[g]),
         .stable_next (stable_next[g]),
         .pending     (pending[g])
      );
   end

   mbd_merge u_merge (
      .pending     (pending),
      .stable_next (stable_next),
      .consume     (cmd.consume),
      .grant       (grant),
      .result      (result)
   );

   // output register plus skid entry
   logic             out_valid_ff, out_valid_in;
   mbd_rsp_data_type out_data_ff, out_data_in;
   logic             skid_valid_ff, skid_valid_in;
   mbd_rsp_data_type skid_data_ff, skid_data_in;
   logic             take_out;

   assign take_out = out_valid_ff && rsp.ready;

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (skid_valid_ff) begin
         if (take_out) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end else if (accept) begin
         if (!out_valid_ff || take_out) begin
            out_valid_in = 1'b1;
            out_data_in  = result;
         end else begin
            skid_valid_in = 1'b1;
            skid_data_in  = result;
         end
      end else if (take_out) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign req.ready          = !skid_valid_ff;
   assign rsp.valid          = out_valid_ff;
   assign rsp.press_event    = out_data_ff.press_event;
   assign rsp.stable_pressed = out_data_ff.stable_pressed;

endmodule
